/* design/quadrature_detent_position_counter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_POSITION_COUNTER_MACROS_SVH
`define QUADRATURE_DETENT_POSITION_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QDPC_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define QDPC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

/* design/qdpc_pkg.sv */
// ----------------------------------------------------------------------------
// qdpc_pkg
// Types, codes and the Gray-code step decoder for the detent counter.
// ----------------------------------------------------------------------------
package qdpc_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 2;
    localparam int POS_W  = 16;

    // APB byte address of the max_position register
    localparam logic [ADDR_W-1:0] ADDR_MAX_POSITION = '0;

    // Reset value of the max_position register
    localparam logic [POS_W-1:0] MAX_POSITION_RESET = 16'd100;
    localparam logic [POS_W-1:0] POSITION_RESET     = 16'd1;

    // Step decoded from one phase transition
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    // Detent event code on the result word
    typedef enum logic [1:0] {
        EVT_NONE = 2'd0,
        EVT_UP   = 2'd1,
        EVT_DOWN = 2'd2
    } detent_t;

    // Up: 00->10, 10->11, 11->01, 01->00; down is the reverse
    function automatic step_t step_decode(input logic [1:0] old_phase,
                                          input logic [1:0] new_phase);
        step_t step;
        case ({old_phase, new_phase}) inside
            4'b0010, 4'b1011, 4'b1101, 4'b0100: step = STEP_UP;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: step = STEP_DOWN;
            default:                            step = STEP_NONE;
        endcase
        return step;
    endfunction

endpackage

/* design/quadrature_detent_position_counter.sv */
// ----------------------------------------------------------------------------
// quadrature_detent_position_counter
// Decodes sampled A/B phase lines into detents and a saturating position.
//
// Input channel (in_valid/in_ready) carries one sample of phase_a/phase_b per
// word. Each accepted word yields exactly one result word (position,
// detent_event, illegal_jump) on out_valid/out_ready in the next cycle.
// Throughput is one word per cycle: the whole state update is a single pass
// of logic into the result and state registers. in_ready stays high while
// the result register is empty or being taken, so a stall on the output
// holds the result and blocks only the next input word.
// The first sample after reset just records the phase. A double-bit jump is
// flagged and takes no step. max_position sits at APB byte address 0
// (0 acts as 1). Reset empties the result register, clears the phase and
// step state, sets position to 1 and max_position to 100.
// ----------------------------------------------------------------------------
module quadrature_detent_position_counter
    import qdpc_pkg::*;
#(
    parameter int STEPS_PER_DETENT = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // sample channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                phase_a,
    input  logic                phase_b,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    position,
    output logic [1:0]          detent_event,
    output logic                illegal_jump
);

    // accumulator holds -STEPS..+STEPS before the detent check
    localparam int ACC_W = $clog2(STEPS_PER_DETENT + 1) + 1;
    localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(STEPS_PER_DETENT);
    localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_ZERO  = '0;

    logic [POS_W-1:0]        max_position_reg;
    logic [1:0]              last_phase_reg, last_phase_next;
    logic                    primed_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]        position_reg, position_next;
    detent_t                 event_reg, event_next;
    logic                    illegal_reg, illegal_next;
    logic                    out_valid_reg;

    logic                    in_fire;
    logic [1:0]              cur_phase;
    step_t                   step;
    logic                    moved;
    logic                    reversal;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_sum;
    logic [POS_W-1:0]        limit;

    // APB: single register, written on the access phase
    assign pready = 1'b1;
    assign prdata = {{(DATA_W-POS_W){1'b0}}, max_position_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_position_reg <= MAX_POSITION_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_POSITION))
        begin
            max_position_reg <= pwdata[POS_W-1:0];
        end
    end

    // handshake: result register frees up when taken
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // decode and update
    assign cur_phase = {phase_a, phase_b};
    assign step      = step_decode(last_phase_reg, cur_phase);
    assign moved     = primed_reg && (cur_phase != last_phase_reg);
    assign limit     = (max_position_reg == '0) ? POSITION_RESET : max_position_reg;
    assign reversal  = ((step == STEP_UP) && (acc_reg < ACC_ZERO)) ||
                       ((step == STEP_DOWN) && (acc_reg > ACC_ZERO));
    assign acc_base  = reversal ? ACC_ZERO : acc_reg;
    assign acc_sum   = (step == STEP_UP) ? (acc_base + ACC_ONE) : (acc_base - ACC_ONE);

    always_comb
    begin
        last_phase_next = moved || !primed_reg ? cur_phase : last_phase_reg;
        acc_next        = acc_reg;
        position_next   = position_reg;
        event_next      = EVT_NONE;
        illegal_next    = 1'b0;
        if (moved)
        begin
            if (step == STEP_NONE)
            begin
                illegal_next = 1'b1;
            end
            else if (acc_sum >= ACC_LIMIT)
            begin
                acc_next   = ACC_ZERO;
                event_next = EVT_UP;
                if (position_reg < limit)
                begin
                    position_next = position_reg + POS_W'(1);
                end
            end
            else if (acc_sum <= -ACC_LIMIT)
            begin
                acc_next   = ACC_ZERO;
                event_next = EVT_DOWN;
                if (position_reg > POSITION_RESET)
                begin
                    position_next = position_reg - POS_W'(1);
                end
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= '0;
            primed_reg     <= 1'b0;
            acc_reg        <= ACC_ZERO;
            position_reg   <= POSITION_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                last_phase_reg <= last_phase_next;
                primed_reg     <= 1'b1;
                acc_reg        <= acc_next;
                position_reg   <= position_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            event_reg   <= event_next;
            illegal_reg <= illegal_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = position_reg;
    assign detent_event = event_reg;
    assign illegal_jump = illegal_reg;

endmodule

/* design/qdpc_checker.sv */
// ----------------------------------------------------------------------------
// qdpc_checker
// Port-level checks on the detent counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadrature_detent_position_counter_macros.svh"

module qdpc_checker
    import qdpc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [POS_W-1:0] position,
    input logic [1:0]       detent_event,
    input logic             illegal_jump
);

    // stalled result stays up
    `QDPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // every accepted sample shows a result next cycle
    `QDPC_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && in_ready, out_valid, "no result one cycle after accept")

    // an illegal jump never completes a detent
    `QDPC_ASSERT_NOW(a_illegal_no_event, clk, rst_n, out_valid && illegal_jump, detent_event == EVT_NONE, "detent on illegal jump")

    // position never drops below one
    `QDPC_ASSERT_NOW(a_pos_floor, clk, rst_n, out_valid, position != '0, "position reached zero")

endmodule

bind quadrature_detent_position_counter qdpc_checker u_qdpc_checker (.*);
